@@ design/olir_pkg.sv @@
// Shared types and constants for the ordered list insert/remove/find unit.
package olir_pkg;

    localparam int CAPACITY = 8;
    localparam int POS_W    = 8;
    localparam int DATA_W   = 32;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_FIND   = 2'd2,
        REQ_NONE   = 2'd3
    } req_kind_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0]               req_type;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } req_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [POS_W-1:0] found_position;
        logic [POS_W-1:0] entry_count;
    } rsp_t;

    // Broadcast command from the controller to every cell of the chain
    typedef struct packed {
        logic                     do_insert;
        logic                     do_remove;
        logic [POS_W-1:0]         sel_index;
        logic signed [DATA_W-1:0] value;
    } cell_cmd_t;

endpackage

@@ design/olir_cell.sv @@
// One list entry cell: holds a value, shifts to either neighbor, compares.
module olir_cell
    import olir_pkg::*;
(
    input  logic                     clk,
    input  cell_cmd_t                cmd,
    input  logic [POS_W-1:0]         cell_index,
    input  logic signed [DATA_W-1:0] left_data,
    input  logic signed [DATA_W-1:0] right_data,
    output logic signed [DATA_W-1:0] data,
    output logic                     match
);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (cmd.do_insert)
        begin
            if (cell_index == cmd.sel_index)
                data_next = cmd.value;
            else if (cell_index > cmd.sel_index)
                data_next = left_data;
        end
        else if (cmd.do_remove)
        begin
            if (cell_index >= cmd.sel_index)
                data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign match = (data_reg == cmd.value);

endmodule

@@ design/ordered_list_insert_remove_find_unit.sv @@
// Top level of the ordered list unit: request decode, cell chain, result register.
//
// Keeps an ordered list of up to CAPACITY signed 32-bit values in a chain of
// cells, one entry per cell. A request (insert at a 1-based position, remove
// at a position, or find the first position holding a value) is taken on any
// clock edge where start is high; busy is always low, so a new request can be
// issued every cycle. The result is registered and appears on result with done
// high in the cycle after the request edge; done is high for a single cycle per
// request and result holds until the next request: the receiver cannot stall,
// so capture it when done is high. Throughput is one request per cycle, set by
// the cell chain, where every cell shifts from its neighbor in the same edge,
// and by the first-match priority pick across the cell comparators. Insert into
// a full list reports full before checking the position; remove or find on an
// empty list reports empty first. Bad positions and the unused request code
// report invalid position and leave the list untouched.
module ordered_list_insert_remove_find_unit
    import olir_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t request,
    output logic done,
    output rsp_t result
);

    logic [POS_W-1:0] count_reg;
    logic [POS_W-1:0] count_next;
    rsp_t             result_reg;
    rsp_t             result_next;
    logic             done_reg;

    cell_cmd_t                cmd;
    logic signed [DATA_W-1:0] cell_data [CAPACITY];
    logic [CAPACITY-1:0]      cell_match;

    logic                     accept;
    logic [POS_W:0]           pos_ext;
    logic [POS_W:0]           count_ext;
    logic                     hit;
    logic [POS_W-1:0]         hit_pos;

    // The chain updates every cell in the same edge, so a request is always welcome
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign pos_ext   = {1'b0, request.position};
    assign count_ext = {1'b0, count_reg};

    // First live cell whose value matches; scan from the top so the lowest wins
    always_comb
    begin
        hit     = 1'b0;
        hit_pos = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (cell_match[i] && (POS_W'(i) < count_reg))
            begin
                hit     = 1'b1;
                hit_pos = POS_W'(i + 1);
            end
        end
    end

    // Decode the request into a cell command and the result
    always_comb
    begin
        cmd.do_insert  = 1'b0;
        cmd.do_remove  = 1'b0;
        cmd.sel_index  = request.position - POS_W'(1);
        cmd.value      = request.value;
        count_next     = count_reg;
        result_next.status         = ST_OK;
        result_next.found_position = '0;

        case (req_kind_t'(request.req_type))
            REQ_INSERT:
            begin
                if (count_reg == POS_W'(CAPACITY))
                    result_next.status = ST_FULL;
                else if (request.position == '0 || pos_ext > count_ext + 1'b1)
                    result_next.status = ST_BADPOS;
                else
                begin
                    cmd.do_insert = accept;
                    count_next    = count_reg + 1'b1;
                end
            end
            REQ_REMOVE:
            begin
                if (count_reg == '0)
                    result_next.status = ST_EMPTY;
                else if (request.position == '0 || request.position > count_reg)
                    result_next.status = ST_BADPOS;
                else
                begin
                    cmd.do_remove = accept;
                    count_next    = count_reg - 1'b1;
                end
            end
            REQ_FIND:
            begin
                if (count_reg == '0)
                    result_next.status = ST_EMPTY;
                else if (hit)
                    result_next.found_position = hit_pos;
                else
                    result_next.status = ST_NOTFOUND;
            end
            default:
            begin
                result_next.status = ST_BADPOS;
            end
        endcase

        result_next.entry_count = count_next;
    end

    // Cell chain: each cell takes from its lower neighbor on insert and from
    // its upper neighbor on remove; the ends feed themselves
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_in;
        logic signed [DATA_W-1:0] right_in;

        if (g == 0)
        begin : g_first
            assign left_in = cell_data[g];
        end
        else
        begin : g_mid_l
            assign left_in = cell_data[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_in = cell_data[g];
        end
        else
        begin : g_mid_r
            assign right_in = cell_data[g+1];
        end

        olir_cell u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .cell_index (POS_W'(g)),
            .left_data  (left_in),
            .right_data (right_in),
            .data       (cell_data[g]),
            .match      (cell_match[g])
        );
    end

    // Hold the count; advance it and present the result on accepted requests
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
                count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Count never exceeds the number of cells
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= POS_W'(CAPACITY))
        else $error("list count above capacity");

    // A result appears only in the cycle after an accepted request
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start))
        else $error("result strobe without request");

    // Reported count matches the held count
    a_count_report: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.entry_count == count_reg)
        else $error("reported count differs from held count");

    // A nonzero position comes only with a successful find
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.found_position != '0) |-> result.status == ST_OK)
        else $error("found position with failing status");

    // Full is reported only when every cell is in use
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_FULL) |-> count_reg == POS_W'(CAPACITY))
        else $error("full status with free cells");

endmodule
